>>> rtl/ialu_pkg.sv
// ----------------------------------------------------------------------------
// Integer ALU package
// Shared widths, opcode and status codes, and the word that moves along the
// divider chain.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int DataWidth = 32;
  localparam int NumCells  = DataWidth;

  typedef logic [DataWidth-1:0] word_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_DIV = 3'd2,
    OP_MUL = 3'd3,
    OP_MOD = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_MOD_ZERO = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t op;
    status_t st;
    logic    neg_q;
    logic    neg_r;
    word_t   res;
    word_t   rem;
    word_t   dq;
    word_t   dvs;
  } cell_t;

endpackage

>>> rtl/ialu_req_if.sv
// ----------------------------------------------------------------------------
// Integer ALU request channel
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface ialu_req_if;
  import ialu_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [2:0]                  opcode;
  logic signed [DataWidth-1:0] operand_a;
  logic signed [DataWidth-1:0] operand_b;

  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

>>> rtl/ialu_rsp_if.sv
// ----------------------------------------------------------------------------
// Integer ALU response channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface ialu_rsp_if;
  import ialu_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] result;
  logic [1:0]                  status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

>>> rtl/integer_alu_with_divide.sv
// ----------------------------------------------------------------------------
// Signed integer ALU with divide
// Add, subtract, multiply, divide and modulo on 32-bit two's complement words.
// ----------------------------------------------------------------------------
// The block accepts one operation word every cycle while the response side
// keeps taking results, and a new word can enter while earlier ones are
// still in the chain. Each word passes, in order, one front stage that
// decodes the opcode and does the add, subtract and multiply, a chain of 32
// divider cells that each produce one quotient bit, and one output stage that
// fixes the signs and holds the result word for the response channel. Every
// stage has its own valid bit and a ready that looks only at the next stage,
// so stalls on the response side fill bubbles before they reach the request
// side. Division truncates toward zero, the remainder takes the sign of the
// dividend, and the most negative value divided by minus one wraps to itself.
// A zero divisor gives status 1 (divide) or 2 (modulo) and an unknown opcode
// gives status 3, each with a result of zero.
module integer_alu_with_divide (
  input  logic       clk,
  input  logic       rst,
  ialu_req_if.sink   req,
  ialu_rsp_if.source rsp
);
  import ialu_pkg::*;

  logic  cell_valid [NumCells+1];
  cell_t cell_data  [NumCells+1];
  logic  cell_ready [NumCells+1];

  ialu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_valid (cell_valid[0]),
    .out_data  (cell_data[0]),
    .out_ready (cell_ready[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    ialu_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[i]),
      .in_data   (cell_data[i]),
      .in_ready  (cell_ready[i]),
      .out_valid (cell_valid[i+1]),
      .out_data  (cell_data[i+1]),
      .out_ready (cell_ready[i+1])
    );
  end

  ialu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cell_valid[NumCells]),
    .in_data  (cell_data[NumCells]),
    .in_ready (cell_ready[NumCells]),
    .rsp      (rsp)
  );
endmodule

>>> rtl/ialu_front.sv
// ----------------------------------------------------------------------------
// Integer ALU front stage
// Decodes the opcode, computes add, subtract and multiply, and prepares the
// operand magnitudes and signs for the divider chain.
// ----------------------------------------------------------------------------
module ialu_front (
  input  logic            clk,
  input  logic            rst,
  ialu_req_if.sink        req,
  output logic            out_valid,
  output ialu_pkg::cell_t out_data,
  input  logic            out_ready
);
  import ialu_pkg::*;

  word_t a;
  word_t b;
  cell_t nxt;
  logic  valid;
  cell_t data;

  always_comb begin
    a         = word_t'(req.operand_a);
    b         = word_t'(req.operand_b);
    nxt.op    = OP_ADD;
    nxt.st    = ST_OK;
    nxt.neg_q = a[DataWidth-1] ^ b[DataWidth-1];
    nxt.neg_r = a[DataWidth-1];
    nxt.res   = '0;
    nxt.rem   = '0;
    nxt.dq    = a[DataWidth-1] ? (~a + word_t'(1)) : a;
    nxt.dvs   = b[DataWidth-1] ? (~b + word_t'(1)) : b;
    unique case (req.opcode)
      OP_ADD: begin
        nxt.op  = OP_ADD;
        nxt.res = a + b;
      end
      OP_SUB: begin
        nxt.op  = OP_SUB;
        nxt.res = a - b;
      end
      OP_MUL: begin
        nxt.op  = OP_MUL;
        nxt.res = a * b;
      end
      OP_DIV: begin
        nxt.op = OP_DIV;
        if (b == '0) begin
          nxt.st = ST_DIV_ZERO;
        end
      end
      OP_MOD: begin
        nxt.op = OP_MOD;
        if (b == '0) begin
          nxt.st = ST_MOD_ZERO;
        end
      end
      default: begin
        nxt.st = ST_UNKNOWN;
      end
    endcase
  end

  assign req.ready = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      data <= nxt;
    end
  end
endmodule

>>> rtl/ialu_cell.sv
// ----------------------------------------------------------------------------
// Integer ALU divider cell
// One restoring division step: shifts one dividend bit into the partial
// remainder and one quotient bit into the shift register.
// ----------------------------------------------------------------------------
module ialu_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ialu_pkg::cell_t in_data,
  output logic            in_ready,
  output logic            out_valid,
  output ialu_pkg::cell_t out_data,
  input  logic            out_ready
);
  import ialu_pkg::*;

  logic [DataWidth:0] trial;
  logic [DataWidth:0] diff;
  logic               fits;
  cell_t              nxt;
  logic               valid;
  cell_t              data;

  always_comb begin
    trial   = {in_data.rem, in_data.dq[DataWidth-1]};
    diff    = trial - {1'b0, in_data.dvs};
    fits    = !diff[DataWidth];
    nxt     = in_data;
    nxt.rem = fits ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
    nxt.dq  = {in_data.dq[DataWidth-2:0], fits};
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      data <= nxt;
    end
  end
endmodule

>>> rtl/ialu_back.sv
// ----------------------------------------------------------------------------
// Integer ALU output stage
// Applies the signs to quotient and remainder, selects the result by opcode,
// zeroes it on an error status and holds it for the response channel.
// ----------------------------------------------------------------------------
module ialu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ialu_pkg::cell_t in_data,
  output logic            in_ready,
  ialu_rsp_if.source      rsp
);
  import ialu_pkg::*;

  word_t res;
  logic  valid;

  always_comb begin
    case (in_data.op) inside
      OP_ADD, OP_SUB, OP_MUL: res = in_data.res;
      OP_DIV:  res = in_data.neg_q ? (~in_data.dq + word_t'(1)) : in_data.dq;
      OP_MOD:  res = in_data.neg_r ? (~in_data.rem + word_t'(1)) : in_data.rem;
      default: res = '0;
    endcase
    if (in_data.st != ST_OK) begin
      res = '0;
    end
  end

  assign in_ready  = !valid || rsp.ready;
  assign rsp.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      rsp.result <= $signed(res);
      rsp.status <= in_data.st;
    end
  end
endmodule
